// ===== rtl/core/ctc_pkg.sv =====
`timescale 1ns / 1ps
package ctc_pkg;

    // Matrix geometry
    localparam int MaxBins  = 64;
    localparam int IdxW     = $clog2(MaxBins);
    localparam int AddrW    = 2 * IdxW;
    localparam int Depth    = MaxBins * MaxBins;
    localparam int CovW     = 32;
    localparam int CorrW    = 16;
    localparam int FracBits = 14;

    // Widths inside the arithmetic
    localparam int ProdW = 62;              // product of two positive 31-bit values
    localparam int RootW = 32;              // floor(sqrt) of the product
    localparam int SqW   = ProdW + 1;       // room for res + bit in the root loop
    localparam int QuoW  = 17;              // quotient bits kept before saturation
    localparam int NumW  = 48;              // 2*|cov|*2^14 + S
    localparam int DivW  = RootW + 1 + QuoW; // shifted divisor width
    localparam int DivCntW = $clog2(QuoW + 1); // divide step counter width

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONPOS = 2'd1,
        ST_SAT    = 2'd2
    } status_t;

    // Control sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_CHECK,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DV_GO,
        S_DV_WAIT
    } state_t;

    // Handshake between sequencer and an iterative unit
    typedef struct packed {
        logic start;
    } unit_ctl_t;

endpackage

// ===== rtl/core/ctc_mem.sv =====
`timescale 1ns / 1ps
module ctc_mem (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ctc_pkg::AddrW-1:0]   waddr,
    input  logic [ctc_pkg::CovW-1:0]    wdata,
    input  logic [ctc_pkg::AddrW-1:0]   raddr,
    output logic [ctc_pkg::CovW-1:0]    rdata
);
    import ctc_pkg::*;

    logic [CovW-1:0] mem [Depth];
    logic [CovW-1:0] rdata_reg;

    // Covariance store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/ctc_sqrt.sv =====
`timescale 1ns / 1ps
module ctc_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctc_pkg::unit_ctl_t          ctl,
    input  logic [ctc_pkg::ProdW-1:0]   x,
    output logic                        done,
    output logic [ctc_pkg::RootW-1:0]   root
);
    import ctc_pkg::*;

    logic           run_reg, run_next;
    logic [SqW-1:0] x_reg, x_next;
    logic [SqW-1:0] res_reg, res_next;
    logic [SqW-1:0] bit_reg, bit_next;
    logic [SqW-1:0] trial;

    // One digit pair per cycle
    always_comb
    begin
        run_next = run_reg;
        x_next   = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        trial    = res_reg + bit_reg;
        if (ctl.start)
        begin
            run_next = 1'b1;
            x_next   = {1'b0, x};
            res_next = '0;
            bit_next = SqW'(1) << (ProdW);
        end
        else if (run_reg)
        begin
            if (bit_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (x_reg >= trial)
                begin
                    x_next   = x_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = run_reg && (bit_reg == '0);
    assign root = res_reg[RootW-1:0];

endmodule

// ===== rtl/core/ctc_div.sv =====
`timescale 1ns / 1ps
module ctc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctc_pkg::unit_ctl_t          ctl,
    input  logic [ctc_pkg::CovW-1:0]    mag,
    input  logic [ctc_pkg::RootW-1:0]   root,
    output logic                        done,
    output logic                        ovf,
    output logic [ctc_pkg::QuoW-1:0]    quo
);
    import ctc_pkg::*;

    logic               run_reg, run_next;
    logic [DivCntW-1:0] cnt_reg, cnt_next;
    logic [DivW-1:0]    rem_reg, rem_next;
    logic [DivW-1:0]    dsh_reg, dsh_next;
    logic [QuoW-1:0]    quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic [DivW-1:0]    num;
    logic [DivW-1:0]    dfull;

    // Rounded quotient (2N + S) / (2S), one bit per cycle
    always_comb
    begin
        num      = DivW'({mag, {(FracBits + 1){1'b0}}}) + DivW'(root);
        dfull    = {root, 1'b0, {QuoW{1'b0}}};
        run_next = run_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        quo_next = quo_reg;
        ovf_next = ovf_reg;
        if (ctl.start)
        begin
            run_next = 1'b1;
            cnt_next = DivCntW'(QuoW);
            rem_next = num;
            dsh_next = dfull >> 1;
            quo_next = '0;
            ovf_next = (num >= dfull);
        end
        else if (run_reg)
        begin
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
            end
            else
            begin
                if (rem_reg >= dsh_reg)
                begin
                    rem_next = rem_reg - dsh_reg;
                    quo_next = {quo_reg[QuoW-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[QuoW-2:0], 1'b0};
                end
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done = run_reg && (cnt_reg == '0);
    assign ovf  = ovf_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/core/covariance_to_correlation.sv =====
`timescale 1ns / 1ps
// Covariance matrix store with correlation readout.
// Input items: pulse start with kind/row/col/cov_value while busy is low.
// A load item (kind 0) writes cov_value at (row, col) in the same edge and
// the block stays free; it gives no result. Loads can follow one per cycle.
// A query item (kind 1) reads (row,col), (row,row) and (col,col) from the
// store, one read per cycle, multiplies the diagonals, takes an iterative
// integer square root and a restoring division, and returns one item:
// corr_value in Q1.14, out_row, out_col and status.
// A query holds busy until its result is given; when a diagonal is not
// positive it ends after the check, with no root or divide. The result
// shows in the same cycle that busy falls, and the next item can be taken
// at the edge ending that cycle.
// The result is shown for exactly one cycle, marked by result_valid; the
// receiver cannot stall it, so it must take the item in that cycle.
// Reset clears the control state only; the store contents are undefined until
// loaded, and queries must touch loaded entries only.
module covariance_to_correlation (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        kind,
    input  logic [ctc_pkg::IdxW-1:0]    row,
    input  logic [ctc_pkg::IdxW-1:0]    col,
    input  logic signed [ctc_pkg::CovW-1:0] cov_value,
    output logic                        result_valid,
    output logic signed [ctc_pkg::CorrW-1:0] corr_value,
    output logic [ctc_pkg::IdxW-1:0]    out_row,
    output logic [ctc_pkg::IdxW-1:0]    out_col,
    output logic [1:0]                  status
);
    import ctc_pkg::*;

    state_t            state_reg, state_next;
    logic [IdxW-1:0]   row_reg, row_next;
    logic [IdxW-1:0]   col_reg, col_next;
    logic [CovW-1:0]   crc_reg, crc_next;
    logic [CovW-1:0]   crr_reg, crr_next;
    logic [CovW-1:0]   ccc_reg, ccc_next;
    logic [ProdW-1:0]  prod_reg, prod_next;
    logic              rv_reg, rv_next;
    logic [CorrW-1:0]  corr_reg, corr_next;
    logic [1:0]        stat_reg, stat_next;

    logic              accept;
    logic              mem_we;
    logic [AddrW-1:0]  raddr;
    logic [CovW-1:0]   rdata;
    unit_ctl_t         sq_ctl, dv_ctl;
    logic              sq_done, dv_done, dv_ovf;
    logic [RootW-1:0]  root;
    logic [QuoW-1:0]   quo;
    logic              neg;
    logic [CovW-1:0]   mag;

    assign accept = start && (state_reg == S_IDLE);
    assign mem_we = accept && (kind == KIND_LOAD);
    assign neg    = crc_reg[CovW-1];
    assign mag    = neg ? (~crc_reg + 1'b1) : crc_reg;

    ctc_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr ({row, col}),
        .wdata (cov_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    ctc_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sq_ctl),
        .x     (prod_reg),
        .done  (sq_done),
        .root  (root)
    );

    ctc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dv_ctl),
        .mag   (mag),
        .root  (root),
        .done  (dv_done),
        .ovf   (dv_ovf),
        .quo   (quo)
    );

    // Sequencer: three reads, check, multiply, root, divide, saturate
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        crc_next     = crc_reg;
        crr_next     = crr_reg;
        ccc_next     = ccc_reg;
        prod_next    = prod_reg;
        rv_next      = 1'b0;
        corr_next    = corr_reg;
        stat_next    = stat_reg;
        raddr        = {row_reg, col_reg};
        sq_ctl.start = 1'b0;
        dv_ctl.start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (kind == KIND_QUERY))
                begin
                    row_next   = row;
                    col_next   = col;
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                raddr      = {row_reg, col_reg};
                state_next = S_RD1;
            end
            S_RD1:
            begin
                raddr      = {row_reg, row_reg};
                crc_next   = rdata;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                raddr      = {col_reg, col_reg};
                crr_next   = rdata;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                ccc_next   = rdata;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (crr_reg[CovW-1] || (crr_reg == '0) ||
                    ccc_reg[CovW-1] || (ccc_reg == '0))
                begin
                    corr_next  = '0;
                    stat_next  = ST_NONPOS;
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    prod_next  = crr_reg[CovW-2:0] * ccc_reg[CovW-2:0];
                    state_next = S_SQ_GO;
                end
            end
            S_SQ_GO:
            begin
                sq_ctl.start = 1'b1;
                state_next   = S_SQ_WAIT;
            end
            S_SQ_WAIT:
            begin
                if (sq_done)
                begin
                    state_next = S_DV_GO;
                end
            end
            S_DV_GO:
            begin
                dv_ctl.start = 1'b1;
                state_next   = S_DV_WAIT;
            end
            S_DV_WAIT:
            begin
                if (dv_done)
                begin
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                    stat_next  = ST_OK;
                    if (!neg)
                    begin
                        if (dv_ovf || (quo > QuoW'(32767)))
                        begin
                            corr_next = CorrW'(32767);
                            stat_next = ST_SAT;
                        end
                        else
                        begin
                            corr_next = quo[CorrW-1:0];
                        end
                    end
                    else
                    begin
                        if (dv_ovf || (quo > QuoW'(32768)))
                        begin
                            corr_next = CorrW'(32768);
                            stat_next = ST_SAT;
                        end
                        else
                        begin
                            corr_next = ~quo[CorrW-1:0] + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        crc_reg  <= crc_next;
        crr_reg  <= crr_next;
        ccc_reg  <= ccc_next;
        prod_reg <= prod_next;
        corr_reg <= corr_next;
        stat_reg <= stat_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign corr_value   = corr_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;
    assign status       = stat_reg;

    // Checks
    a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while busy");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_QUERY)) |=> busy)
        else $error("query item not taken");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_LOAD)) |=> (!busy && !result_valid))
        else $error("load item caused work");

    a_nonpos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_NONPOS)) |-> (corr_value == '0))
        else $error("non-positive variance with nonzero value");

endmodule

// ===== tb/covariance_to_correlation_test.sv =====
`timescale 1ns / 1ps
module covariance_to_correlation_test;
    import ctc_pkg::*;

    typedef struct {
        logic              kind;
        logic [IdxW-1:0]   row;
        logic [IdxW-1:0]   col;
        logic [CovW-1:0]   cov;
    } cov_item_t;

    typedef struct {
        logic [CorrW-1:0]  corr;
        logic [IdxW-1:0]   row;
        logic [IdxW-1:0]   col;
        logic [1:0]        status;
    } corr_item_t;

    localparam longint CycleLimit = 2000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic kind;
    logic [IdxW-1:0] row;
    logic [IdxW-1:0] col;
    logic signed [CovW-1:0] cov_value;
    logic result_valid;
    logic signed [CorrW-1:0] corr_value;
    logic [IdxW-1:0] out_row;
    logic [IdxW-1:0] out_col;
    logic [1:0] status;

    cov_item_t  pending_items[$];
    corr_item_t expected_corr[$];
    logic [CovW-1:0] cov_shadow[Depth];
    bit              loaded[Depth];
    bit              fill_done;
    bit              quiet_run;
    int              mismatches;
    int              sent_count;
    longint          cycles;

    covariance_to_correlation dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .row(row), .col(col), .cov_value(cov_value),
        .result_valid(result_valid), .corr_value(corr_value),
        .out_row(out_row), .out_col(out_col), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Integer square root, bit by bit
    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] one;
        res = 0;
        one = 64'd1 << 62;
        while (one > x)
            one = one >> 2;
        while (one != 0)
        begin
            if (x >= res + one)
            begin
                x = x - (res + one);
                res = (res >> 1) + one;
            end
            else
                res = res >> 1;
            one = one >> 2;
        end
        return res;
    endfunction

    // Correlation of the stored entries for a query
    function automatic corr_item_t correlate(logic [IdxW-1:0] r, logic [IdxW-1:0] c);
        corr_item_t res;
        longint crc;
        longint crr;
        longint ccc;
        logic [63:0] prod;
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] quo;
        crc = longint'($signed(cov_shadow[{r, c}]));
        crr = longint'($signed(cov_shadow[{r, r}]));
        ccc = longint'($signed(cov_shadow[{c, c}]));
        res.row = r;
        res.col = c;
        res.corr = '0;
        res.status = ST_OK;
        if (crr <= 0 || ccc <= 0)
            res.status = ST_NONPOS;
        else
        begin
            prod = crr * ccc;
            root = int_sqrt(prod);
            mag = (crc < 0) ? -crc : crc;
            quo = (2 * (mag << FracBits) + root) / (2 * root);
            if (crc >= 0)
            begin
                if (quo > 32767)
                begin
                    quo = 32767;
                    res.status = ST_SAT;
                end
                res.corr = quo[15:0];
            end
            else
            begin
                if (quo > 32768)
                begin
                    quo = 32768;
                    res.status = ST_SAT;
                end
                res.corr = 16'(17'h10000 - quo[16:0]);
            end
        end
        return res;
    endfunction

    function automatic logic [CovW-1:0] rand_cov(bit positive);
        logic [CovW-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(1, 20);
            1: v = 32'h7fffffff - $urandom_range(0, 3);
            2: v = $urandom_range(1, 100000);
            3: v = $urandom >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        if (positive)
        begin
            v[31] = 1'b0;
            if (v == 0)
                v = 1;
        end
        return v;
    endfunction

    task automatic push_load(logic [IdxW-1:0] r, logic [IdxW-1:0] c, logic [CovW-1:0] v);
        cov_item_t it;
        it.kind = KIND_LOAD;
        it.row = r;
        it.col = c;
        it.cov = v;
        pending_items = {pending_items, it};
        loaded[{r, c}] = 1'b1;
    endtask

    // Queries only touch loaded entries; missing ones are loaded first
    task automatic push_query(logic [IdxW-1:0] r, logic [IdxW-1:0] c);
        cov_item_t it;
        if (!loaded[{r, r}])
            push_load(r, r, rand_cov($urandom_range(0, 9) != 0));
        if (!loaded[{c, c}])
            push_load(c, c, rand_cov($urandom_range(0, 9) != 0));
        if (!loaded[{r, c}])
            push_load(r, c, rand_cov(1'b0));
        it.kind = KIND_QUERY;
        it.row = r;
        it.col = c;
        it.cov = $urandom;
        pending_items = {pending_items, it};
    endtask

    // Stimulus
    initial
    begin
        logic [IdxW-1:0] r;
        logic [IdxW-1:0] c;
        // directed: perfect correlation, anti-correlation, saturation, non-positive
        push_load(0, 0, 32'd100);
        push_load(1, 1, 32'd100);
        push_load(0, 1, 32'd100);
        push_query(0, 1);
        push_load(1, 0, -32'sd100);
        push_query(1, 0);
        push_query(0, 0);
        push_load(0, 1, 32'h7fffffff);
        push_query(0, 1);
        push_load(1, 0, 32'h80000000);
        push_query(1, 0);
        push_load(63, 63, 32'h7fffffff);
        push_load(62, 62, 32'd1);
        push_load(63, 62, 32'h7fffffff);
        push_query(63, 62);
        push_load(2, 2, 32'd0);
        push_load(2, 63, 32'd5);
        push_query(2, 63);
        push_load(3, 3, 32'hffffffff);
        push_load(63, 3, 32'd5);
        push_query(63, 3);
        push_load(62, 63, 32'h3fffffff);
        push_query(62, 63);
        // random: mostly small index range so queries hit loaded data
        for (int n = 0; n < 1600; n++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                r = IdxW'($urandom);
                c = IdxW'($urandom);
            end
            else
            begin
                r = IdxW'($urandom_range(0, 7));
                c = IdxW'($urandom_range(0, 7));
            end
            if ($urandom_range(0, 1) == 0)
                push_load(r, c, rand_cov(r == c && $urandom_range(0, 7) != 0));
            else
                push_query(r, c);
        end
        fill_done = 1'b1;
    end

    // Driver
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        kind = 1'b0;
        row = '0;
        col = '0;
        cov_value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cov_item_t it;
        if (rst_n)
        begin
            // item taken on this edge
            if (start && !busy)
            begin
                if (kind == KIND_LOAD)
                    cov_shadow[{row, col}] = cov_value;
                else
                    expected_corr = {expected_corr, correlate(row, col)};
                sent_count++;
            end
            if ((!start || !busy) && pending_items.size() != 0
                && (quiet_run || $urandom_range(0, 99) >= 22))
            begin
                it = pending_items.pop_front();
                start <= 1'b1;
                kind <= it.kind;
                row <= it.row;
                col <= it.col;
                cov_value <= it.cov;
            end
            else if (!start || !busy)
                start <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        corr_item_t want;
        if (rst_n && result_valid)
        begin
            if (expected_corr.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row %0d col %0d", out_row, out_col);
            end
            else
            begin
                want = expected_corr.pop_front();
                if (corr_value !== want.corr || out_row !== want.row
                    || out_col !== want.col || status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("got corr %h row %0d col %0d st %0d, want %h %0d %0d %0d",
                                 corr_value, out_row, out_col, status,
                                 want.corr, want.row, want.col, want.status);
                end
            end
        end
    end

    // Quiet window with no idling, plus cycle limit
    always @(posedge clk)
    begin
        cycles++;
        quiet_run <= (cycles % 20000) > 14000;
        if (cycles > CycleLimit)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        wait (fill_done);
        wait (pending_items.size() == 0 && !start);
        wait (expected_corr.size() == 0 && !busy);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_corr.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
